// ===== rtl/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the differential drive mixer
// Fixed-point constants for the premix scaling, the pivot weight divider and
// the final blend, plus the structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package ddm_pkg;

    // Full-scale joystick and drive magnitude.
    localparam int FULL_SCALE = 127;

    // One in Q16.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Reset value of the pivot throttle limit.
    localparam logic [6:0] LIMIT_RESET = 7'd32;

    // 65536 = 127 * 516 + 4, so m * 65536 / 127 = m * 516 + (4 * m) / 127.
    localparam logic [9:0] SCALE_MUL = 10'd516;

    // Reciprocal of 127 in Q24, rounded up; exact for numerators below 2^17.
    localparam logic [17:0] RECIP_127 = 18'd132105;
    localparam int RECIP_SHIFT = 24;

    // Pivot weight divider: 16 quotient bits over four stages.
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS = 4;

    // Bias that makes the arithmetic shift by 32 truncate toward zero.
    localparam logic signed [44:0] TRUNC_BIAS = 45'sd4294967295;

    // Magnitude and sign of one side's premix times throttle.
    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } ddm_side_t;

    // Running state of the pivot weight division.
    typedef struct packed {
        logic        act;
        logic [6:0]  lim;
        logic [6:0]  rem;
        logic [15:0] quo;
    } ddm_div_t;

endpackage

// ===== rtl/ddm_front.sv =====
// ----------------------------------------------------------------------------
// ddm_front: premix selection and throttle product
// Picks each side's premix from the signs of X and Y, multiplies it by Y and
// seeds the pivot weight division with |Y| and the limit.
// ----------------------------------------------------------------------------
module ddm_front
    import ddm_pkg::*;
(
    input  logic              clk,
    input  logic signed [7:0] x,
    input  logic signed [7:0] y,
    input  logic [6:0]        lim,
    output logic signed [7:0] x_q,
    output ddm_side_t         left_q,
    output ddm_side_t         right_q,
    output ddm_div_t          div_q
);

    logic [7:0]         ay;
    logic signed [9:0]  x10;
    logic signed [9:0]  y10;
    logic signed [9:0]  pl;
    logic signed [9:0]  pr;
    logic signed [19:0] prod_l;
    logic signed [19:0] prod_r;
    logic [19:0]        abs_l;
    logic [19:0]        abs_r;
    ddm_side_t          left_next;
    ddm_side_t          right_next;
    ddm_div_t           div_next;

    // Premix per side, chosen by the signs of X and Y.
    always_comb
    begin
        x10 = {{2{x[7]}}, x};
        y10 = {{2{y[7]}}, y};
        ay  = y[7] ? 8'(~y + 8'd1) : y;
        if (!y[7])
        begin
            pl = x[7] ? 10'(10'sd127 + x10) : 10'sd127;
            pr = x[7] ? 10'sd127 : 10'(10'sd127 - x10);
        end
        else
        begin
            pl = x[7] ? 10'sd127 : 10'(10'sd127 - x10);
            pr = x[7] ? 10'(10'sd127 + x10) : 10'sd127;
        end
    end

    // Premix times throttle, split into sign and magnitude.
    always_comb
    begin
        prod_l = 20'(pl) * 20'(y10);
        prod_r = 20'(pr) * 20'(y10);
        abs_l  = prod_l[19] ? 20'(-prod_l) : prod_l;
        abs_r  = prod_r[19] ? 20'(-prod_r) : prod_r;
        left_next.neg  = prod_l[19];
        left_next.mag  = abs_l[14:0];
        right_next.neg = prod_r[19];
        right_next.mag = abs_r[14:0];
    end

    // Division seed: the weight is only nonzero while |Y| is below the limit.
    always_comb
    begin
        div_next.act = ({1'b0, lim} > ay);
        div_next.lim = lim;
        div_next.rem = div_next.act ? ay[6:0] : 7'd0;
        div_next.quo = 16'd0;
    end

    always_ff @(posedge clk)
    begin
        x_q     <= x;
        left_q  <= left_next;
        right_q <= right_next;
        div_q   <= div_next;
    end

endmodule

// ===== rtl/ddm_scale.sv =====
// ----------------------------------------------------------------------------
// ddm_scale: scaled drive in Q16
// Computes the product times 65536 / 127, truncated toward zero, in two
// register stages: reciprocal multiply for the small remainder term, then the
// integer multiply, add and sign.
// ----------------------------------------------------------------------------
module ddm_scale
    import ddm_pkg::*;
(
    input  logic               clk,
    input  ddm_side_t          side,
    output logic signed [25:0] drive
);

    logic [34:0]        recip_prod;
    logic [10:0]        frac_next;
    logic [10:0]        frac_reg;
    ddm_side_t          side_reg;
    logic [24:0]        mag_full;
    logic signed [25:0] drive_next;
    logic signed [25:0] drive_reg;

    // First stage: floor(4 * m / 127) through the Q24 reciprocal.
    always_comb
    begin
        recip_prod = 35'({side.mag, 2'b00}) * 35'(RECIP_127);
        frac_next  = recip_prod[RECIP_SHIFT +: 11];
    end

    // Second stage: m * 516 plus the remainder term, then the sign.
    always_comb
    begin
        mag_full   = 25'(side_reg.mag) * 25'(SCALE_MUL) + 25'(frac_reg);
        drive_next = side_reg.neg ? -$signed({1'b0, mag_full})
                                  : $signed({1'b0, mag_full});
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side;
        frac_reg  <= frac_next;
        drive_reg <= drive_next;
    end

    assign drive = drive_reg;

endmodule

// ===== rtl/ddm_div_stage.sv =====
// ----------------------------------------------------------------------------
// ddm_div_stage: one stage of the pivot weight divider
// Restoring division of |Y| * 65536 by the limit with DIV_STEPS quotient
// bits per stage. The remainder stays below the limit when the limit is nonzero.
// ----------------------------------------------------------------------------
module ddm_div_stage
    import ddm_pkg::*;
(
    input  logic     clk,
    input  ddm_div_t d_in,
    output ddm_div_t d_out
);

    logic [7:0] r2;
    ddm_div_t   d_next;
    ddm_div_t   d_reg;

    // Shift-and-subtract steps for this stage.
    always_comb
    begin
        d_next = d_in;
        r2     = 8'd0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r2 = {d_next.rem, 1'b0};
            if (r2 >= {1'b0, d_next.lim})
            begin
                d_next.rem = 7'(r2 - {1'b0, d_next.lim});
                d_next.quo = {d_next.quo[14:0], 1'b1};
            end
            else
            begin
                d_next.rem = r2[6:0];
                d_next.quo = {d_next.quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

// ===== rtl/ddm_blend.sv =====
// ----------------------------------------------------------------------------
// ddm_blend: pivot blend, truncation and saturation
// Weights the scaled drives against the in-place pivot, then truncates the
// Q32 sums toward zero and saturates them to -127..127.
// ----------------------------------------------------------------------------
module ddm_blend
    import ddm_pkg::*;
(
    input  logic               clk,
    input  ddm_div_t           div,
    input  logic signed [7:0]  x,
    input  logic signed [25:0] drive_l,
    input  logic signed [25:0] drive_r,
    output logic [7:0]         left,
    output logic [7:0]         right
);

    logic [16:0]        g;
    logic [16:0]        w;
    logic signed [17:0] gs;
    logic signed [17:0] ws;
    logic signed [8:0]  x9;
    logic signed [8:0]  nx9;
    logic signed [43:0] drv_l_next;
    logic signed [43:0] drv_r_next;
    logic signed [26:0] piv_l_next;
    logic signed [26:0] piv_r_next;
    logic signed [43:0] drv_l_reg;
    logic signed [43:0] drv_r_reg;
    logic signed [26:0] piv_l_reg;
    logic signed [26:0] piv_r_reg;
    logic signed [44:0] acc_l;
    logic signed [44:0] acc_r;
    logic [7:0]         left_next;
    logic [7:0]         right_next;
    logic [7:0]         left_reg;
    logic [7:0]         right_reg;

    // Divide a Q32 sum by 2^32 toward zero and clamp to the drive range.
    function automatic logic [7:0] trunc_sat(input logic signed [44:0] acc);
        logic signed [44:0] adj;
        logic signed [12:0] q;
        adj = acc + (acc[44] ? TRUNC_BIAS : 45'sd0);
        q   = $signed(adj[44:32]);
        if (q > 13'sd127)
            return 8'h7f;
        else if (q < -13'sd127)
            return 8'h81;
        else
            return q[7:0];
    endfunction

    // First stage: weights and the four products.
    always_comb
    begin
        g          = div.act ? {1'b0, div.quo} : ONE_Q16;
        w          = 17'(ONE_Q16 - g);
        gs         = $signed({1'b0, g});
        ws         = $signed({1'b0, w});
        x9         = {x[7], x};
        nx9        = 9'(-x9);
        drv_l_next = 44'(gs) * 44'(drive_l);
        drv_r_next = 44'(gs) * 44'(drive_r);
        piv_l_next = 27'(ws) * 27'(x9);
        piv_r_next = 27'(ws) * 27'(nx9);
    end

    // Second stage: sum, truncate and saturate.
    always_comb
    begin
        acc_l      = 45'(drv_l_reg) + 45'($signed({piv_l_reg, 16'h0000}));
        acc_r      = 45'(drv_r_reg) + 45'($signed({piv_r_reg, 16'h0000}));
        left_next  = trunc_sat(acc_l);
        right_next = trunc_sat(acc_r);
    end

    always_ff @(posedge clk)
    begin
        drv_l_reg <= drv_l_next;
        drv_r_reg <= drv_r_next;
        piv_l_reg <= piv_l_next;
        piv_r_reg <= piv_r_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign left  = left_reg;
    assign right = right_reg;

endmodule

// ===== rtl/differential_drive_mixer_core.sv =====
// ----------------------------------------------------------------------------
// differential_drive_mixer_core: joystick to differential drive mixer
// Turns a joystick X (turn) and Y (throttle) word into left and right motor
// drive values, blending a throttle-scaled premix with an in-place pivot.
//
// Usage:
//   Input: a word (turn_x, throttle_y) is taken at a clock edge where start
//   is high and busy is low. busy never rises, so a word may be offered on
//   every cycle.
//   Output: each result word appears on left_drive/right_drive for one cycle
//   with done high. The receiver cannot hold results off and none are needed:
//   the pipeline never stalls.
//   Pipeline: each word passes through eight register stages (input,
//   premix, four divider stages, two blend stages). Throughput is one word
//   per cycle, since every stage takes a new word on each edge.
//   Configuration: cfg_write with cfg_data sets the pivot throttle limit;
//   write it only while no word is in flight.
//   Reset: rst_n clears all pending words and sets the limit to 32.
// ----------------------------------------------------------------------------
module differential_drive_mixer_core
    import ddm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] turn_x,
    input  logic signed [7:0] throttle_y,
    output logic              done,
    output logic signed [7:0] left_drive,
    output logic signed [7:0] right_drive,
    input  logic              cfg_write,
    input  logic [6:0]        cfg_data
);

    localparam int NUM_STAGES = DIV_STAGES + 4;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [6:0]            lim_reg;
    logic signed [7:0]     x_reg;
    logic signed [7:0]     y_reg;
    logic signed [7:0]     x_front;
    ddm_side_t             left_side;
    ddm_side_t             right_side;
    ddm_div_t              div_bus [0:DIV_STAGES];
    logic signed [7:0]     x_pipe_reg [0:DIV_STAGES-1];
    logic signed [25:0]    drive_l;
    logic signed [25:0]    drive_r;
    logic signed [25:0]    drive_l_dly_reg [0:DIV_STAGES-3];
    logic signed [25:0]    drive_r_dly_reg [0:DIV_STAGES-3];
    logic [7:0]            left_w;
    logic [7:0]            right_w;

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    // Valid bits travel alongside the data stages.
    assign vld_next = {vld_reg[NUM_STAGES-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            lim_reg <= LIMIT_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_write)
                lim_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            x_reg <= turn_x;
            y_reg <= throttle_y;
        end
    end

    // Premix and throttle product.
    ddm_front u_front (
        .clk     (clk),
        .x       (x_reg),
        .y       (y_reg),
        .lim     (lim_reg),
        .x_q     (x_front),
        .left_q  (left_side),
        .right_q (right_side),
        .div_q   (div_bus[0])
    );

    // Scaled drives, two stages each.
    ddm_scale u_scale_l (
        .clk   (clk),
        .side  (left_side),
        .drive (drive_l)
    );

    ddm_scale u_scale_r (
        .clk   (clk),
        .side  (right_side),
        .drive (drive_r)
    );

    // Pivot weight divider stages.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        ddm_div_stage u_div (
            .clk   (clk),
            .d_in  (div_bus[s]),
            .d_out (div_bus[s+1])
        );
    end

    // Align X and the drives with the end of the divider.
    always_ff @(posedge clk)
    begin
        x_pipe_reg[0]      <= x_front;
        drive_l_dly_reg[0] <= drive_l;
        drive_r_dly_reg[0] <= drive_r;
        for (int i = 1; i < DIV_STAGES; i++)
            x_pipe_reg[i] <= x_pipe_reg[i-1];
        for (int i = 1; i < DIV_STAGES - 2; i++)
        begin
            drive_l_dly_reg[i] <= drive_l_dly_reg[i-1];
            drive_r_dly_reg[i] <= drive_r_dly_reg[i-1];
        end
    end

    // Blend with the pivot, truncate and saturate.
    ddm_blend u_blend (
        .clk     (clk),
        .div     (div_bus[DIV_STAGES]),
        .x       (x_pipe_reg[DIV_STAGES-1]),
        .drive_l (drive_l_dly_reg[DIV_STAGES-3]),
        .drive_r (drive_r_dly_reg[DIV_STAGES-3]),
        .left    (left_w),
        .right   (right_w)
    );

    assign done        = vld_reg[NUM_STAGES-1];
    assign left_drive  = $signed(left_w);
    assign right_drive = $signed(right_w);

endmodule

// ===== verif/differential_drive_mixer_core_test.sv =====
// ----------------------------------------------------------------------------
// differential_drive_mixer_core_test: self-checking bench for the drive mixer
// Drives joystick words into the mixer and predicts each left/right drive pair
// with a behavioral Q16 mixer. The pivot limit is swept through its extremes
// between phases. Directed corners come first, then random words sent in
// bursts with random gaps.
// ----------------------------------------------------------------------------
module differential_drive_mixer_core_test
    import ddm_pkg::*;
();

    localparam int RUN_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEMS_PER_PHASE = 128;
    localparam longint Q16 = 65536;

    // One predicted result word, with the inputs that caused it.
    typedef struct {
        logic signed [7:0] turn;
        logic signed [7:0] throttle;
        logic signed [7:0] left;
        logic signed [7:0] right;
    } drive_pair_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic signed [7:0] turn_x;
    logic signed [7:0] throttle_y;
    logic              done;
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              cfg_write;
    logic [6:0]        cfg_data;

    drive_pair_t pending_drives[$];
    logic [6:0]  pivot_limit;
    int          errors = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    differential_drive_mixer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .turn_x      (turn_x),
        .throttle_y  (throttle_y),
        .done        (done),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle count and the run timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("differential_drive_mixer_core_test: done, errors");
            $finish;
        end
    end

    // Blend one side's scaled premix with its pivot term, truncate, saturate.
    function automatic logic signed [7:0] blend_side(input longint premix, input longint y,
                                                     input longint pivot, input longint w);
        longint drive;
        longint acc;
        longint q;
        drive = premix * y * Q16 / FULL_SCALE;
        acc = (Q16 - w) * drive + w * (pivot * Q16);
        q = acc / (Q16 * Q16);
        if (q > FULL_SCALE)
            q = FULL_SCALE;
        else if (q < -FULL_SCALE)
            q = -FULL_SCALE;
        return q[7:0];
    endfunction

    // Predict the left and right drive of one joystick word.
    function automatic drive_pair_t mix_drive(input logic signed [7:0] x,
                                              input logic signed [7:0] y,
                                              input logic [6:0] lim);
        longint      sx;
        longint      sy;
        longint      ay;
        longint      w;
        longint      pl;
        longint      pr;
        drive_pair_t d;
        sx = x;
        sy = y;
        ay = (sy < 0) ? -sy : sy;
        // The signs of X and Y pick which side runs at full scale.
        if (sy >= 0)
        begin
            pl = (sx >= 0) ? FULL_SCALE : FULL_SCALE + sx;
            pr = (sx >= 0) ? FULL_SCALE - sx : FULL_SCALE;
        end
        else
        begin
            pl = (sx >= 0) ? FULL_SCALE - sx : FULL_SCALE;
            pr = (sx >= 0) ? FULL_SCALE : FULL_SCALE + sx;
        end
        // A zero limit always lands in the first branch, so nothing divides by zero.
        if (ay >= longint'(lim))
            w = 0;
        else
            w = Q16 - (ay * Q16) / longint'(lim);
        d.turn = x;
        d.throttle = y;
        d.left = blend_side(pl, sy, sx, w);
        d.right = blend_side(pr, sy, -sx, w);
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    // Compare every result word against the oldest prediction.
    always @(posedge clk)
    begin
        drive_pair_t want;
        if (rst_n && done)
        begin
            if (pending_drives.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word left %0d right %0d",
                                          left_drive, right_drive));
            end
            else
            begin
                want = pending_drives.pop_front();
                if (left_drive !== want.left)
                    report_mismatch($sformatf("x %0d y %0d: left %0d, want %0d",
                                              want.turn, want.throttle, left_drive, want.left));
                if (right_drive !== want.right)
                    report_mismatch($sformatf("x %0d y %0d: right %0d, want %0d",
                                              want.turn, want.throttle, right_drive,
                                              want.right));
            end
        end
    end

    // Send one word; the sender idles for a random gap, possibly none, between bursts of random length.
    // Only the low byte of each argument is sent.
    task automatic send_word(input int x, input int y);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        turn_x <= 8'(x);
        throttle_y <= 8'(y);
        do
            @(posedge clk);
        while (busy);
        pending_drives.push_back(mix_drive(8'(x), 8'(y), pivot_limit));
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_drives.size() != 0)
            @(negedge clk);
    endtask

    // Write the pivot limit while nothing is in flight.
    task automatic set_limit(input logic [6:0] value);
        wait_drained();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        pivot_limit = value;
    endtask

    // Sign quadrants, full-scale and out-of-range inputs at the reset limit.
    task automatic test_throttle_turn_corners();
        send_word(127, 127);
        send_word(-127, 127);
        send_word(127, -127);
        send_word(-127, -127);
        send_word(0, 0);
        send_word(-128, -128);
        send_word(-128, 127);
        send_word(127, -128);
        send_word(60, 10);
        send_word(-60, -10);
        send_word(5, 31);
        send_word(5, 32);
        send_word(-5, -32);
        send_word(100, -31);
    endtask

    // Pivot limit at zero, one and full scale, with throttle at the boundary.
    task automatic test_pivot_limit_edges();
        set_limit(7'd0);
        send_word(50, 0);
        send_word(-128, 3);
        set_limit(7'd1);
        send_word(50, 0);
        send_word(50, 1);
        send_word(-50, -1);
        set_limit(7'd127);
        send_word(127, 126);
        send_word(-127, -127);
        send_word(10, -64);
    endtask

    // Random words over several limits; half the draws keep the throttle near the pivot band.
    task automatic test_random_mix();
        logic [6:0] lim;
        int         x;
        int         y;
        int         mode;
        int         mag;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: lim = 7'd127;
                1: lim = 7'd1;
                2: lim = 7'd0;
                3: lim = 7'd64;
                7: lim = LIMIT_RESET;
                default: lim = 7'($urandom_range(2, 126));
            endcase
            set_limit(lim);
            // One phase runs back to back with no gaps at all.
            if (phase == 4)
                burst_left = ITEMS_PER_PHASE + 8;
            repeat (ITEMS_PER_PHASE)
            begin
                mode = $urandom_range(0, 3);
                case (mode)
                    0:
                    begin
                        x = $urandom;
                        y = $urandom;
                    end
                    1, 2:
                    begin
                        x = $urandom_range(0, 254) - 127;
                        mag = $urandom_range(0, (int'(lim) < 126) ? int'(lim) + 1 : 127);
                        y = $urandom_range(0, 1) ? mag : -mag;
                    end
                    default:
                    begin
                        x = $urandom_range(0, 254) - 127;
                        y = $urandom_range(0, 254) - 127;
                    end
                endcase
                send_word(x, y);
            end
        end
    endtask

    // Reset, run each test in turn, then let the pipeline empty.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        turn_x = '0;
        throttle_y = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        pivot_limit = LIMIT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_throttle_turn_corners();
        test_pivot_limit_edges();
        test_random_mix();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("differential_drive_mixer_core_test: done, clean");
        else
            $display("differential_drive_mixer_core_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ddm_pkg.sv
rtl/ddm_front.sv
rtl/ddm_scale.sv
rtl/ddm_div_stage.sv
rtl/ddm_blend.sv
rtl/differential_drive_mixer_core.sv
verif/differential_drive_mixer_core_test.sv
